// ===== design/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants
// Widths, register indexes, input codes and the datapath control group
// used by the step period speed smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

   // field and register widths
   localparam int unsigned REG_W    = 16;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned MS_W     = 17;
   localparam int unsigned IDX_W    = 2;

   // gain times scale fits in 29 bits, so the quotient does too
   localparam int unsigned SCALE_W  = 13;
   localparam int unsigned NUM_W    = 29;
   localparam int unsigned WGT_W    = 17;
   localparam int unsigned PROD_W   = WGT_W + NUM_W;
   localparam int unsigned ACC_W    = PROD_W + 1;
   localparam int unsigned CNT_W    = $clog2(NUM_W);

   localparam logic [SCALE_W-1:0] RAW_SCALE  = SCALE_W'(8000);
   localparam logic [WGT_W-1:0]   WGT_ONE    = WGT_W'(65536);
   localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(32768);
   localparam logic [MS_W-1:0]    MS_MAX     = MS_W'(131071);
   localparam logic [SPEED_W-1:0] SPEED_MAX  = SPEED_W'(65535);

   // register indexes
   localparam logic [IDX_W-1:0] REG_SPEED_GAIN   = 2'd0;
   localparam logic [IDX_W-1:0] REG_SMOOTH_WGT   = 2'd1;
   localparam logic [IDX_W-1:0] REG_STOP_TIMEOUT = 2'd2;

   // reset values of the registers
   localparam logic [REG_W-1:0] GAIN_RESET    = REG_W'(4096);
   localparam logic [REG_W-1:0] WGT_RESET     = REG_W'(0);
   localparam logic [REG_W-1:0] TIMEOUT_RESET = REG_W'(200);

   // input item kinds
   localparam logic FUNC_PULSE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // sequencer to datapath controls
   typedef struct packed {
      logic load_period;
      logic mul_gain;
      logic div_step;
      logic mul_old;
      logic mul_new;
   } dp_ctrl_type;

endpackage

`default_nettype wire

// ===== design/sps_if.sv =====
// ----------------------------------------------------------------------------
// sps_if: channel interfaces
// Valid/ready channels for step beats in and speed beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_req_if import sps_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [PERIOD_W-1:0] period_ms;

   modport source (output valid, output func, output period_ms, input ready);
   modport sink   (input valid, input func, input period_ms, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed;
   logic               stopped;

   modport source (output valid, output speed, output stopped, input ready);
   modport sink   (input valid, input speed, input stopped, output ready);
endinterface

`default_nettype wire

// ===== design/sps_datapath.sv =====
// ----------------------------------------------------------------------------
// sps_datapath: shared multiplier and serial divider
// One 17x29 multiplier serves the gain scaling and both blend terms; a
// restoring divider produces one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_datapath import sps_pkg::*; (
   input  wire logic                clock,
   input  wire dp_ctrl_type         ctrl,
   input  wire logic [PERIOD_W-1:0] period_ms,
   input  wire logic [REG_W-1:0]    speed_gain,
   input  wire logic [REG_W-1:0]    smooth_weight,
   input  wire logic [SPEED_W-1:0]  speed_now,
   output logic      [SPEED_W-1:0]  speed_blend
);

   logic [PERIOD_W-1:0] div_ff,  div_in;
   logic [NUM_W-1:0]    quo_ff,  quo_in;
   logic [PERIOD_W-1:0] rem_ff,  rem_in;
   logic [ACC_W-1:0]    acc_ff,  acc_in;

   logic [WGT_W-1:0]    mul_a;
   logic [NUM_W-1:0]    mul_b;
   logic [PROD_W-1:0]   product;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W+1:0] trial;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (ctrl.mul_gain) begin
         mul_a = {1'b0, speed_gain};
         mul_b = NUM_W'(RAW_SCALE);
      end else if (ctrl.mul_old) begin
         mul_a = {1'b0, smooth_weight};
         mul_b = NUM_W'(speed_now);
      end else if (ctrl.mul_new) begin
         mul_a = WGT_ONE - {1'b0, smooth_weight};
         mul_b = quo_ff;
      end
   end

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   // restoring divide step: shift in the next numerator bit, trial subtract
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};

   always_comb begin
      div_in = div_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      if (ctrl.load_period) begin
         div_in = period_ms;
      end
      if (ctrl.mul_gain) begin
         quo_in = product[NUM_W-1:0];
         rem_in = '0;
      end else if (ctrl.div_step) begin
         if (!trial[PERIOD_W+1]) begin
            rem_in = trial[PERIOD_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[PERIOD_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end else if (ctrl.mul_old) begin
         acc_in = {1'b0, product} + ROUND_HALF;
      end else if (ctrl.mul_new) begin
         acc_in = acc_ff + {1'b0, product};
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   // drop the rounding bits and saturate at full speed
   always_comb begin
      if (|acc_ff[ACC_W-1:SPEED_W+16]) begin
         speed_blend = SPEED_MAX;
      end else begin
         speed_blend = acc_ff[SPEED_W+15:16];
      end
   end

endmodule

`default_nettype wire

// ===== design/sps_ctrl.sv =====
// ----------------------------------------------------------------------------
// sps_ctrl: sequencer and speed state
// Runs each nonzero-period pulse through scaling, division and blending,
// handles millisecond ticks and the stop timeout and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_ctrl import sps_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_func,
   input  wire logic [PERIOD_W-1:0] req_period_ms,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [SPEED_W-1:0]  rsp_speed,
   output logic                     rsp_stopped,
   input  wire logic [REG_W-1:0]    stop_timeout_ms,
   input  wire logic [SPEED_W-1:0]  speed_blend,
   output logic      [SPEED_W-1:0]  speed_now,
   output dp_ctrl_type              dp_ctrl
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TICK  = 3'd1;
   localparam logic [2:0] ST_GAIN  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OLD   = 3'd4;
   localparam logic [2:0] ST_NEW   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]         state_ff,   state_in;
   logic [CNT_W-1:0]   cnt_ff,     cnt_in;
   logic [SPEED_W-1:0] speed_ff,   speed_in;
   logic [MS_W-1:0]    ms_ff,      ms_in;
   logic               seen_ff,    seen_in;
   logic               valid_ff,   valid_in;
   logic [SPEED_W-1:0] out_spd_ff, out_spd_in;
   logic               out_stp_ff, out_stp_in;

   logic               accept;
   logic               out_free;
   logic [MS_W-1:0]    ms_inc;
   logic               stop_hit;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_speed   = out_spd_ff;
   assign rsp_stopped = out_stp_ff;
   assign speed_now   = speed_ff;

   // saturating millisecond count and the stop check
   assign ms_inc   = (ms_ff < MS_MAX) ? ms_ff + MS_W'(1) : ms_ff;
   assign stop_hit = seen_ff && (ms_inc > {1'b0, stop_timeout_ms}) && (speed_ff != '0);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      speed_in   = speed_ff;
      ms_in      = ms_ff;
      seen_in    = seen_ff;
      valid_in   = valid_ff && !rsp_ready;
      out_spd_in = out_spd_ff;
      out_stp_in = out_stp_ff;
      dp_ctrl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_TICK) begin
                  state_in = ST_TICK;
               end else begin
                  ms_in   = '0;
                  seen_in = 1'b1;
                  if (req_period_ms != '0) begin
                     dp_ctrl.load_period = 1'b1;
                     state_in            = ST_GAIN;
                  end
               end
            end
         end
         ST_TICK: begin
            // hold off while a stop beat would find the result register full
            if (!stop_hit || out_free) begin
               ms_in    = ms_inc;
               state_in = ST_IDLE;
               if (stop_hit) begin
                  speed_in   = '0;
                  valid_in   = 1'b1;
                  out_spd_in = '0;
                  out_stp_in = 1'b1;
               end
            end
         end
         ST_GAIN: begin
            dp_ctrl.mul_gain = 1'b1;
            cnt_in           = '0;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            dp_ctrl.div_step = 1'b1;
            cnt_in           = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_OLD;
            end
         end
         ST_OLD: begin
            dp_ctrl.mul_old = 1'b1;
            state_in        = ST_NEW;
         end
         ST_NEW: begin
            dp_ctrl.mul_new = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               speed_in   = speed_blend;
               valid_in   = 1'b1;
               out_spd_in = speed_blend;
               out_stp_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         speed_ff <= '0;
         ms_ff    <= '0;
         seen_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         ms_ff    <= ms_in;
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
      end
   end

   // payload and loop counter
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      out_spd_ff <= out_spd_in;
      out_stp_ff <= out_stp_in;
   end

endmodule

`default_nettype wire

// ===== design/step_period_speed_smoother.sv =====
// ----------------------------------------------------------------------------
// step_period_speed_smoother: smoothed speed from step periods
// Turns step periods into a smoothed, clamped speed and signals a stop
// once pulses cease for longer than the timeout.
// ----------------------------------------------------------------------------
// usage
//   req_ch takes one beat per step pulse (func 0, period in ms) or per
//   millisecond tick (func 1). rsp_ch gives at most one beat per request:
//   the new speed as an unsigned Q16.0 integer, with stopped set for a timeout beat.
//   csr_wr_en/csr_index/csr_wdata write gain, weight and timeout; write
//   them only while the block is idle.
// sequence
//   a pulse with a nonzero period runs from acceptance through one
//   multiply for the gain scaling, the one-bit-a-cycle restoring divider,
//   two multiplies on the shared multiplier for the blend and a load of
//   the result, which waits for a free output register. req_ch.ready
//   stays low meanwhile. a tick goes through the tick state only.
// reset and stalls
//   reset clears speed, elapsed count and pulse history and loads the
//   register defaults. a result waits in the output register until taken;
//   a new request is accepted meanwhile, and only a later result holds the
//   sequencer until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module step_period_speed_smoother import sps_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   sps_req_if.sink               req_ch,
   sps_rsp_if.source             rsp_ch,
   input  wire logic             csr_wr_en,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0] csr_wdata
);

   logic [REG_W-1:0]   gain_ff,    gain_in;
   logic [REG_W-1:0]   wgt_ff,     wgt_in;
   logic [REG_W-1:0]   timeout_ff, timeout_in;

   dp_ctrl_type        dp_ctrl;
   logic [SPEED_W-1:0] speed_now;
   logic [SPEED_W-1:0] speed_blend;

   // configuration registers
   always_comb begin
      gain_in    = gain_ff;
      wgt_in     = wgt_ff;
      timeout_in = timeout_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_SPEED_GAIN:   gain_in    = csr_wdata;
            REG_SMOOTH_WGT:   wgt_in     = csr_wdata;
            REG_STOP_TIMEOUT: timeout_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= GAIN_RESET;
         wgt_ff     <= WGT_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         gain_ff    <= gain_in;
         wgt_ff     <= wgt_in;
         timeout_ff <= timeout_in;
      end
   end

   // sequencer
   sps_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_func        (req_ch.func),
      .req_period_ms   (req_ch.period_ms),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_speed       (rsp_ch.speed),
      .rsp_stopped     (rsp_ch.stopped),
      .stop_timeout_ms (timeout_ff),
      .speed_blend     (speed_blend),
      .speed_now       (speed_now),
      .dp_ctrl         (dp_ctrl)
   );

   // shared multiplier and divider
   sps_datapath u_datapath (
      .clock         (clock),
      .ctrl          (dp_ctrl),
      .period_ms     (req_ch.period_ms),
      .speed_gain    (gain_ff),
      .smooth_weight (wgt_ff),
      .speed_now     (speed_now),
      .speed_blend   (speed_blend)
   );

endmodule

`default_nettype wire
